// File: sv/ps2mpd_pkg.sv
// Shared types and constants of the PS/2 mouse packet decoder.
`default_nettype none
package ps2mpd_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] EV_MOTION  = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;
  localparam logic [1:0] EV_WHEEL   = 2'd3;

  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_LEFT   = 2'd1;
  localparam logic [1:0] BTN_RIGHT  = 2'd2;
  localparam logic [1:0] BTN_MIDDLE = 2'd3;

  // Bit positions of the pending-event mask, in emission order.
  localparam int PM_MOTION = 0;
  localparam int PM_LEFT   = 1;
  localparam int PM_RIGHT  = 2;
  localparam int PM_MIDDLE = 3;
  localparam int PM_WHEEL  = 4;

  typedef struct packed {
    logic signed [8:0] dx;
    logic signed [9:0] dy;
    logic [2:0]        buttons;
    logic [3:0]        wheel;
    logic [4:0]        mask;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// File: sv/ps2mpd_front.sv
// Front end: filters received bytes, assembles packets and builds event records.
`default_nettype none
module ps2mpd_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,    // rx_byte
  input  wire logic [1:0]            s_tuser,    // from_aux, rx_error
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_wdata,
  input  wire ps2mpd_pkg::q_stat_t   q_stat,
  output logic                       push,
  output ps2mpd_pkg::pkt_t           push_rec
);
  import ps2mpd_pkg::*;

  logic       wheel_mode;
  logic [1:0] byte_count;
  logic [2:0] held_buttons;
  logic [7:0] head;
  logic [7:0] x_byte;
  logic [7:0] y_byte;

  logic       accept;
  logic       use_byte;
  logic       complete;
  logic [1:0] final_count;
  logic [7:0] y_src;
  logic [8:0] y_val;
  logic [2:0] changed;
  logic       motion;
  logic       wheel_hit;

  assign s_tready    = !q_stat.full;
  assign accept      = s_tvalid && s_tready;
  assign use_byte    = accept && s_tuser[0] && !s_tuser[1] &&
                       !(byte_count == 2'd0 && !s_tdata[3]);
  assign final_count = wheel_mode ? 2'd3 : 2'd2;
  assign complete    = use_byte && (byte_count == final_count);

  assign y_src   = wheel_mode ? y_byte : s_tdata;
  assign y_val   = {head[5], y_src};
  assign changed = head[2:0] ^ held_buttons;
  assign motion  = ({head[4], x_byte} != 9'd0) || (y_val != 9'd0);
  assign wheel_hit = wheel_mode && (s_tdata[3:0] != 4'd0);

  always_comb begin
    push_rec.dx      = $signed({head[4], x_byte});
    push_rec.dy      = $signed(10'd0 - {y_val[8], y_val});
    push_rec.buttons = head[2:0];
    push_rec.wheel   = s_tdata[3:0];
    push_rec.mask    = {wheel_hit, changed, motion};
  end

  assign push = complete && (push_rec.mask != 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_mode   <= 1'b0;
      byte_count   <= 2'd0;
      held_buttons <= 3'd0;
    end else if (cfg_we) begin
      wheel_mode <= cfg_wdata;
      byte_count <= 2'd0;
    end else if (use_byte) begin
      if (complete) begin
        byte_count   <= 2'd0;
        held_buttons <= head[2:0];
      end else begin
        byte_count <= byte_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (use_byte) begin
      case (byte_count)
        2'd0:    head   <= s_tdata;
        2'd1:    x_byte <= s_tdata;
        2'd2:    y_byte <= s_tdata;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/ps2mpd_queue.sv
// Short record queue between the front end and the event emitter.
`default_nettype none
module ps2mpd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire ps2mpd_pkg::pkt_t    push_rec,
  input  wire logic                pop,
  output ps2mpd_pkg::pkt_t         pop_rec,
  output ps2mpd_pkg::q_stat_t      q_stat
);
  import ps2mpd_pkg::*;

  pkt_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign q_stat.full  = (count == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_rec      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

endmodule
`default_nettype wire

// File: sv/ps2mpd_back.sv
// Back end: emits record events one per cycle while m_tready is high.
`default_nettype none
module ps2mpd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ps2mpd_pkg::q_stat_t q_stat,
  input  wire ps2mpd_pkg::pkt_t    pop_rec,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [23:0]              m_tdata,   // delta_x, delta_y, zero fill
  output logic [3:0]               m_tuser,   // event_kind, button_id
  output logic                     m_tlast
);
  import ps2mpd_pkg::*;

  pkt_t       work;
  logic [4:0] pending;

  logic       load_out;
  logic [4:0] pending_next;
  logic [1:0] ev_kind;
  logic [1:0] ev_btn;
  logic [8:0] ev_dx;
  logic [9:0] ev_dy;

  always_comb begin
    pending_next = pending;
    ev_kind      = EV_MOTION;
    ev_btn       = BTN_NONE;
    ev_dx        = work.dx;
    ev_dy        = work.dy;
    if (pending[PM_MOTION]) begin
      pending_next[PM_MOTION] = 1'b0;
    end else if (pending[PM_LEFT]) begin
      pending_next[PM_LEFT] = 1'b0;
      ev_kind = work.buttons[0] ? EV_PRESS : EV_RELEASE;
      ev_btn  = BTN_LEFT;
    end else if (pending[PM_RIGHT]) begin
      pending_next[PM_RIGHT] = 1'b0;
      ev_kind = work.buttons[1] ? EV_PRESS : EV_RELEASE;
      ev_btn  = BTN_RIGHT;
    end else if (pending[PM_MIDDLE]) begin
      pending_next[PM_MIDDLE] = 1'b0;
      ev_kind = work.buttons[2] ? EV_PRESS : EV_RELEASE;
      ev_btn  = BTN_MIDDLE;
    end else begin
      pending_next[PM_WHEEL] = 1'b0;
      ev_kind = EV_WHEEL;
      ev_dx   = 9'd0;
      ev_dy   = {{6{work.wheel[3]}}, work.wheel};
    end
  end

  assign load_out = (pending != 5'd0) && (!m_tvalid || m_tready);
  assign pop      = !q_stat.empty &&
                    ((pending == 5'd0) || (load_out && pending_next == 5'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 5'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        pending <= pop_rec.mask;
      end else if (load_out) begin
        pending <= pending_next;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= pop_rec;
    end
    if (load_out) begin
      m_tdata <= {5'd0, ev_dy, ev_dx};
      m_tuser <= {ev_btn, ev_kind};
      m_tlast <= (pending_next == 5'd0);
    end
  end

endmodule
`default_nettype wire

// File: sv/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse packet decoder with wheel support.
//
//   Channel   Direction  Beat contents
//   s_*       in         tdata: rx_byte; tuser: from_aux, rx_error
//   m_*       out        tdata: delta_x, delta_y; tuser: event_kind, button_id;
//                        tlast: last_event
//   cfg_*     in         wheel_mode write, taken whenever cfg_we is high
//
// A received byte is taken whenever s_tready is high; s_tready drops only
// while the two-entry record queue is full. A packet's events, up to five,
// leave the emitter one per cycle while m_tready is high, so its output
// register sets the rate. It is fed from a queue slot via the pending register.
// Reset is synchronous and clears the byte count, buttons, mode and queue.
// While m_tready is low the output register holds its beat and the queue fills.
`default_nettype none
module ps2_mouse_packet_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte
  input  wire logic [1:0]  s_tuser,   // from_aux, rx_error
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // delta_x, delta_y, zero fill
  output logic [3:0]       m_tuser,   // event_kind, button_id
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);
  import ps2mpd_pkg::*;

  q_stat_t q_stat;
  pkt_t    push_rec;
  pkt_t    pop_rec;
  logic    push;
  logic    pop;

  ps2mpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  ps2mpd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .pop_rec (pop_rec),
    .q_stat  (q_stat)
  );

  ps2mpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .pop_rec (pop_rec),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule
`default_nettype wire

// File: tb/sv/ps2_mouse_packet_decoder_tb.sv
// Self-checking testbench for the PS/2 mouse packet decoder, directed table then random packets.
module ps2_mouse_packet_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ps2mpd_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] button;
    logic [8:0] dx;
    logic [9:0] dy;
    logic       last;
  } mouse_event_t;

  typedef enum logic [1:0] {OP_BYTE, OP_MODE} row_op_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_EVENT} row_chk_t;

  typedef struct {
    row_op_t      op;
    logic [7:0]   data;
    logic         aux;
    logic         err;
    row_chk_t     chk;
    mouse_event_t ev;
  } stim_row_t;

  localparam mouse_event_t NO_EVENT = '0;
  localparam int SETTLE_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic [1:0]  s_tuser = 2'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  // Predictor state.
  bit          wheel_on = 1'b0;
  logic [7:0]  pkt_hold [3];
  int          pkt_fill = 0;
  logic [2:0]  btn_held = 3'd0;

  mouse_event_t fresh_events [$];
  mouse_event_t events_due [$];
  mouse_event_t got_ev, want_ev;
  int          fail_count = 0;
  int          fed = 0;
  int          rx_stall = 0;
  bit          quiet = 1'b0;

  stim_row_t dir_rows [26] = '{
    '{OP_BYTE, 8'h08, 1'b0, 1'b0, CHK_NONE,  NO_EVENT},
    '{OP_BYTE, 8'h08, 1'b1, 1'b1, CHK_NONE,  NO_EVENT},
    '{OP_BYTE, 8'h00, 1'b1, 1'b0, CHK_NONE,  NO_EVENT},
    '{OP_BYTE, 8'h08, 1'b1, 1'b0, CHK_NONE,  NO_EVENT},
    '{OP_BYTE, 8'h01, 1'b1, 1'b0, CHK_NONE,  NO_EVENT},
    '{OP_BYTE, 8'h00, 1'b1, 1'b0, CHK_EVENT, '{EV_MOTION, BTN_NONE, 9'd1, 10'd0, 1'b1}},
    '{OP_BYTE, 8'h08, 1'b1, 1'b0, CHK_NONE,  NO_EVENT},
    '{OP_BYTE, 8'h00, 1'b1, 1'b0, CHK_NONE,  NO_EVENT},
    '{OP_BYTE, 8'h00, 1'b1, 1'b0, CHK_NONE,  NO_EVENT},
    '{OP_BYTE, 8'h39, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h00, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h00, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h0E, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'hFF, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'hFF, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_MODE, 8'h01, 1'b0, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h08, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h00, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h00, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'hF0, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h0F, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h05, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h05, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h01, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_BYTE, 8'h08, 1'b1, 1'b0, CHK_MODEL, NO_EVENT},
    '{OP_MODE, 8'h00, 1'b0, 1'b0, CHK_MODEL, NO_EVENT}
  };

  ps2_mouse_packet_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic mouse_event_t make_event(logic [1:0] kind, logic [1:0] button,
                                              int x, int y);
    mouse_event_t e;
    e.kind   = kind;
    e.button = button;
    e.dx     = x[8:0];
    e.dy     = y[9:0];
    e.last   = 1'b0;
    return e;
  endfunction

  task automatic decode_mouse_byte(input logic [7:0] b, input logic aux, input logic err);
    int x, y, w;
    logic [2:0] now_btn, flipped;
    logic [1:0] btn_code [3];
    btn_code = '{BTN_LEFT, BTN_RIGHT, BTN_MIDDLE};
    fresh_events.delete();
    if (!aux || err) return;
    if (pkt_fill == 0 && !b[3]) return;
    if (pkt_fill < 3) pkt_hold[pkt_fill] = b;
    if (pkt_fill + 1 < (wheel_on ? 4 : 3)) begin
      pkt_fill++;
      return;
    end
    pkt_fill = 0;
    x = int'(pkt_hold[1]);
    if (pkt_hold[0][4]) x -= 256;
    y = int'(pkt_hold[2]);
    if (pkt_hold[0][5]) y -= 256;
    y = -y;
    if (x != 0 || y != 0) fresh_events.push_back(make_event(EV_MOTION, BTN_NONE, x, y));
    now_btn = pkt_hold[0][2:0];
    flipped = now_btn ^ btn_held;
    for (int i = 0; i < 3; i++) begin
      if (flipped[i]) begin
        fresh_events.push_back(make_event(now_btn[i] ? EV_PRESS : EV_RELEASE, btn_code[i],
                                          x, y));
      end
    end
    btn_held = now_btn;
    if (wheel_on) begin
      w = int'(b[3:0]);
      if (b[3]) w -= 16;
      if (w != 0) fresh_events.push_back(make_event(EV_WHEEL, BTN_NONE, 0, w));
    end
    if (fresh_events.size() > 0) fresh_events[fresh_events.size() - 1].last = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic aux, input logic err,
                           input bit from_model);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {err, aux};
    do @(posedge clk); while (!s_tready);
    fed++;
    decode_mouse_byte(b, aux, err);
    if (from_model) begin
      foreach (fresh_events[i]) events_due.push_back(fresh_events[i]);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (events_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input bit mode);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
    wheel_on = mode;
    pkt_fill = 0;
  endtask

  task automatic send_packet(input int n_bytes);
    logic [7:0] head, pb;
    bit still;
    int r;
    head = 8'($urandom_range(0, 255));
    head[3] = 1'b1;
    if ($urandom_range(0, 1) == 1) head[2:0] = btn_held;
    still = ($urandom_range(0, 4) == 0);
    if (still) head[5:4] = 2'b00;
    for (int k = 0; k < n_bytes; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 2);
        pb = 8'($urandom_range(0, 255));
        if (r == 2 && pkt_fill == 0) begin
          pb[3] = 1'b0;
          send_byte(pb, 1'b1, 1'b0, 1'b1);
        end else if (r == 1) begin
          send_byte(pb, 1'b1, 1'b1, 1'b1);
        end else begin
          send_byte(pb, 1'b0, 1'($urandom_range(0, 1)), 1'b1);
        end
      end
      if (k == 0) begin
        pb = head;
      end else if (k < 3) begin
        pb = (still || $urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      end else begin
        pb = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) pb[3:0] = 4'd0;
      end
      send_byte(pb, 1'b1, 1'b0, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_ev = '{m_tuser[1:0], m_tuser[3:2], m_tdata[8:0], m_tdata[18:9], m_tlast};
        if (events_due.size() == 0) begin
          $display("%0t: expected no beat, got kind=%0d button=%0d dx=%0d dy=%0d last=%0b",
                   $time, got_ev.kind, got_ev.button, $signed(got_ev.dx),
                   $signed(got_ev.dy), got_ev.last);
          fail_count++;
        end else begin
          want_ev = events_due.pop_front();
          if (got_ev.kind !== want_ev.kind || got_ev.button !== want_ev.button ||
              got_ev.dx !== want_ev.dx || got_ev.dy !== want_ev.dy ||
              got_ev.last !== want_ev.last) begin
            $display("%0t: expected kind=%0d button=%0d dx=%0d dy=%0d last=%0b, ",
                     $time, want_ev.kind, want_ev.button, $signed(want_ev.dx),
                     $signed(want_ev.dy), want_ev.last,
                     "got kind=%0d button=%0d dx=%0d dy=%0d last=%0b",
                     got_ev.kind, got_ev.button,
                     $signed(got_ev.dx), $signed(got_ev.dy), got_ev.last);
            fail_count++;
          end
        end
        rx_stall = quiet ? 0 : $urandom_range(0, 18);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int n_pk, len, psize;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == OP_MODE) begin
        write_mode(dir_rows[i].data[0]);
      end else begin
        send_byte(dir_rows[i].data, dir_rows[i].aux, dir_rows[i].err,
                  dir_rows[i].chk == CHK_MODEL);
        if (dir_rows[i].chk == CHK_EVENT) events_due.push_back(dir_rows[i].ev);
      end
    end
    for (int p = 0; fed < 230; p++) begin
      quiet = ($urandom_range(0, 3) == 0);
      write_mode(p == 0 ? 1'b1 : p == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      psize = wheel_on ? 4 : 3;
      n_pk = $urandom_range(4, 10);
      for (int k = 0; k < n_pk; k++) begin
        if (p == 1 && k == 2) settle();
        len = psize;
        if ($urandom_range(0, 11) == 0) len = $urandom_range(1, psize - 1);
        send_packet(len);
      end
      // A partial packet here is dropped by the mode write that opens the next phase.
      if ($urandom_range(0, 2) == 0) send_packet($urandom_range(1, psize - 1));
    end
    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
sv/ps2mpd_pkg.sv
sv/ps2mpd_front.sv
sv/ps2mpd_queue.sv
sv/ps2mpd_back.sv
sv/ps2_mouse_packet_decoder.sv
tb/sv/ps2_mouse_packet_decoder_tb.sv
